// ===== src/gekq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gekq_pkg;

    localparam int CODE_W  = 10;
    localparam int VAL_W   = 14;
    localparam int THR_W   = 13;
    localparam int ACT_W   = 5;
    localparam int ENTRY_W = ACT_W + 1;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THR = 1'b1;

    localparam logic [THR_W-1:0] PRESS_THR_RESET   = 13'd1800;
    localparam logic [THR_W-1:0] RELEASE_THR_RESET = 13'd800;

    localparam logic             CMD_POP = 1'b1;
    localparam logic [1:0]       EV_KEY  = 2'd0;
    localparam logic [1:0]       EV_ABS  = 2'd1;
    localparam logic [CODE_W-1:0] ABS_X       = 10'd0;
    localparam logic [CODE_W-1:0] ABS_Y       = 10'd1;
    localparam logic [CODE_W-1:0] MODE_BUTTON = 10'd316;

    localparam logic signed [VAL_W-1:0] AXIS_FULL = 14'sd4096;

    localparam logic [ACT_W-1:0] ACT_NONE     = 5'd0;
    localparam logic [ACT_W-1:0] ACT_UP       = 5'd1;
    localparam logic [ACT_W-1:0] ACT_DOWN     = 5'd2;
    localparam logic [ACT_W-1:0] ACT_LEFT     = 5'd3;
    localparam logic [ACT_W-1:0] ACT_RIGHT    = 5'd4;
    localparam logic [ACT_W-1:0] ACT_FIRE     = 5'd5;
    localparam logic [ACT_W-1:0] ACT_USE      = 5'd6;
    localparam logic [ACT_W-1:0] ACT_RUN      = 5'd7;
    localparam logic [ACT_W-1:0] ACT_AUTOMAP  = 5'd8;
    localparam logic [ACT_W-1:0] ACT_STRAFE_L = 5'd9;
    localparam logic [ACT_W-1:0] ACT_STRAFE_R = 5'd10;
    localparam logic [ACT_W-1:0] ACT_WEAPON3  = 5'd11;
    localparam logic [ACT_W-1:0] ACT_WEAPON4  = 5'd12;
    localparam logic [ACT_W-1:0] ACT_WEAPON1  = 5'd13;
    localparam logic [ACT_W-1:0] ACT_WEAPON2  = 5'd14;
    localparam logic [ACT_W-1:0] ACT_ENTER    = 5'd15;
    localparam logic [ACT_W-1:0] ACT_ESCAPE   = 5'd16;
    localparam logic [ACT_W-1:0] ACT_EQUALS   = 5'd17;
    localparam logic [ACT_W-1:0] ACT_MINUS    = 5'd18;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_POP,
        OP_KEY,
        OP_QUIT,
        OP_AXIS
    } op_kind_t;

    // direction an axis sample asks for; HOLD keeps the latch
    typedef enum logic [1:0] {
        DIR_HOLD,
        DIR_ZERO,
        DIR_POS,
        DIR_NEG
    } dir_t;

    typedef enum logic [1:0] {
        LATCH_ZERO,
        LATCH_POS,
        LATCH_NEG
    } latch_t;

    typedef struct packed {
        op_kind_t         kind;
        logic             pressed;
        logic [ACT_W-1:0] action;
        logic             slot;
        dir_t             dir;
    } op_t;

    function automatic logic [ACT_W-1:0] map_code(input logic [CODE_W-1:0] code);
        logic [ACT_W-1:0] act;
        unique case (code) inside
            10'd103:          act = ACT_UP;
            10'd108:          act = ACT_DOWN;
            10'd105:          act = ACT_LEFT;
            10'd106:          act = ACT_RIGHT;
            10'd304, 10'd29:  act = ACT_FIRE;
            10'd305, 10'd57:  act = ACT_USE;
            10'd307, 10'd42:  act = ACT_RUN;
            10'd308, 10'd15:  act = ACT_AUTOMAP;
            10'd310:          act = ACT_STRAFE_L;
            10'd311:          act = ACT_STRAFE_R;
            10'd312:          act = ACT_WEAPON3;
            10'd313:          act = ACT_WEAPON4;
            10'd317:          act = ACT_WEAPON1;
            10'd318:          act = ACT_WEAPON2;
            10'd315, 10'd28:  act = ACT_ENTER;
            10'd314, 10'd1:   act = ACT_ESCAPE;
            10'd115:          act = ACT_EQUALS;
            10'd114:          act = ACT_MINUS;
            default:          act = ACT_NONE;
        endcase
        return act;
    endfunction

    // X axis drives left/right, Y axis up/down
    function automatic logic [ACT_W-1:0] axis_action(input logic slot, input logic negative);
        logic [ACT_W-1:0] act;
        unique case ({slot, negative})
            2'b01:   act = ACT_LEFT;
            2'b00:   act = ACT_RIGHT;
            2'b11:   act = ACT_UP;
            default: act = ACT_DOWN;
        endcase
        return act;
    endfunction

endpackage

`default_nettype wire

// ===== src/gamepad_event_key_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Gamepad event to key-action queue. Every input transaction (an event or a
// pop) yields exactly one result transaction, in order. Items are taken at one
// per cycle while the result side is not stalled; an axis sample that swings a
// latched direction straight to the opposite side holds the back end for a
// second write, since both the release and the press go through the single
// write port of the action RAM. An item is classified into the two-entry op
// queue, then executed, with the result and the RAM read both registered. The
// action queue holds at most QUEUE_DEPTH-1 entries; further pushes are dropped.
// quit_flag reports the sticky mode-button flag as it stands after each
// transaction. Thresholds are written through cfg_we/cfg_index/cfg_data; the
// user must do so only while the block is idle; the block does not enforce it.
module gamepad_event_key_queue import gekq_pkg::*; #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [THR_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    cmd,
    input  wire logic [1:0]              event_type,
    input  wire logic [CODE_W-1:0]       event_code,
    input  wire logic signed [VAL_W-1:0] event_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         key_valid,
    output logic                         key_pressed,
    output logic [ACT_W-1:0]             key_action,
    output logic                         quit_flag
);

    logic push_valid;
    logic push_ready;
    op_t  push_op;
    logic op_valid;
    logic op_pop;
    op_t  op;

    gekq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_op     (push_op)
    );

    gekq_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (op_valid),
        .pop        (op_pop),
        .pop_op     (op)
    );

    gekq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (op_valid),
        .op          (op),
        .op_pop      (op_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .key_valid   (key_valid),
        .key_pressed (key_pressed),
        .key_action  (key_action),
        .quit_flag   (quit_flag)
    );

endmodule

`default_nettype wire

// ===== src/gekq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gekq_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/gekq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gekq_front import gekq_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [THR_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    cmd,
    input  wire logic [1:0]              event_type,
    input  wire logic [CODE_W-1:0]       event_code,
    input  wire logic signed [VAL_W-1:0] event_value,
    output logic                         push_valid,
    input  wire logic                    push_ready,
    output op_t                          push_op
);

    logic [THR_W-1:0] press_thr_reg, press_thr_next;
    logic [THR_W-1:0] release_thr_reg, release_thr_next;

    logic signed [VAL_W-1:0] val_clamped;
    logic signed [VAL_W:0]   val_ext;
    logic signed [VAL_W:0]   pt_s;
    logic signed [VAL_W:0]   rt_s;
    logic [ACT_W-1:0]        mapped;
    dir_t                    dir;

    always_comb
    begin
        press_thr_next   = press_thr_reg;
        release_thr_next = release_thr_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRESS_THR:   press_thr_next   = cfg_data;
                REG_RELEASE_THR: release_thr_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_thr_reg   <= PRESS_THR_RESET;
            release_thr_reg <= RELEASE_THR_RESET;
        end
        else
        begin
            press_thr_reg   <= press_thr_next;
            release_thr_reg <= release_thr_next;
        end
    end

    // axis hysteresis; press compare wins over release compare
    always_comb
    begin
        if (event_value > AXIS_FULL)
            val_clamped = AXIS_FULL;
        else if (event_value < -AXIS_FULL)
            val_clamped = -AXIS_FULL;
        else
            val_clamped = event_value;

        val_ext = (VAL_W+1)'(val_clamped);
        pt_s    = signed'({2'b00, press_thr_reg});
        rt_s    = signed'({2'b00, release_thr_reg});

        if (val_ext >= pt_s)
            dir = DIR_POS;
        else if (val_ext <= -pt_s)
            dir = DIR_NEG;
        else if (val_ext > -rt_s && val_ext < rt_s)
            dir = DIR_ZERO;
        else
            dir = DIR_HOLD;
    end

    assign mapped = map_code(event_code);

    always_comb
    begin
        push_op.kind    = OP_NOP;
        push_op.pressed = (event_value != '0);
        push_op.action  = mapped;
        push_op.slot    = event_code[0];
        push_op.dir     = dir;

        if (cmd == CMD_POP)
        begin
            push_op.kind = OP_POP;
        end
        else
        begin
            case (event_type)
                EV_KEY:
                begin
                    if (event_code == MODE_BUTTON)
                    begin
                        if (event_value == 14'sd1)
                            push_op.kind = OP_QUIT;
                    end
                    else if (event_value <= 14'sd1 && mapped != ACT_NONE)
                    begin
                        push_op.kind = OP_KEY;
                    end
                end
                EV_ABS:
                begin
                    if (event_code == ABS_X || event_code == ABS_Y)
                        push_op.kind = OP_AXIS;
                end
                default: ;
            endcase
        end
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

`default_nettype wire

// ===== src/gekq_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gekq_fifo import gekq_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  op_t       push_op,
    output logic      pop_valid,
    input  wire logic pop,
    output op_t       pop_op
);

    localparam int SLOTS = 2;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    op_t              entry_reg [SLOTS];
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(SLOTS));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entry_reg[rd_idx_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_idx_next = do_push ? wr_idx_reg + 1'b1 : wr_idx_reg;
        rd_idx_next = do_pop ? rd_idx_reg + 1'b1 : rd_idx_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_idx_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== src/gekq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gekq_back import gekq_pkg::*; #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         op_valid,
    input  op_t               op,
    output logic              op_pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              key_valid,
    output logic              key_pressed,
    output logic [ACT_W-1:0]  key_action,
    output logic              quit_flag
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wp_inc, rp_inc;
    latch_t           latch_reg [2];
    latch_t           latch_next [2];
    logic             phase_reg, phase_next;
    logic             quit_reg, quit_next;
    logic             out_valid_reg, out_valid_next;
    logic             hit_reg, hit_next;
    logic             oquit_reg, oquit_next;

    latch_t             old_dir;
    latch_t             want;
    logic               need_rel;
    logic               need_press;
    logic               do_rel;
    logic               two_step;
    logic               out_free;
    logic               go;
    logic               consume;
    logic               push_req;
    logic [ENTRY_W-1:0] push_entry;
    logic               full;
    logic               empty;
    logic               wr_en;
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_data;

    always_comb
    begin
        old_dir = latch_reg[op.slot];
        case (op.dir)
            DIR_ZERO: want = LATCH_ZERO;
            DIR_POS:  want = LATCH_POS;
            DIR_NEG:  want = LATCH_NEG;
            default:  want = old_dir;
        endcase
        need_rel   = (want != old_dir) && (old_dir != LATCH_ZERO);
        need_press = (want != old_dir) && (want != LATCH_ZERO);
    end

    // a swing straight across the centre needs two writes: release first,
    // then the press, once phase_reg is set and the op is taken again
    assign do_rel   = (op.kind == OP_AXIS) && need_rel && !phase_reg;
    assign two_step = do_rel && need_press;
    assign out_free = !out_valid_reg || out_ready;
    assign go       = op_valid && out_free;
    assign consume  = go && !two_step;
    assign op_pop   = consume;

    always_comb
    begin
        push_req   = 1'b0;
        push_entry = {op.pressed, op.action};
        case (op.kind)
            OP_KEY:
            begin
                push_req = 1'b1;
            end
            OP_AXIS:
            begin
                if (do_rel)
                begin
                    push_req   = 1'b1;
                    push_entry = {1'b0, axis_action(op.slot, old_dir == LATCH_NEG)};
                end
                else if (need_press)
                begin
                    push_req   = 1'b1;
                    push_entry = {1'b1, axis_action(op.slot, want == LATCH_NEG)};
                end
            end
            default: ;
        endcase
    end

    assign wp_inc = (wp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign full   = (wp_inc == rp_reg);
    assign empty  = (wp_reg == rp_reg);
    assign wr_en  = go && push_req && !full;
    assign rd_en  = consume && (op.kind == OP_POP) && !empty;

    always_comb
    begin
        wp_next    = wr_en ? wp_inc : wp_reg;
        rp_next    = rd_en ? rp_inc : rp_reg;
        quit_next  = quit_reg || (consume && op.kind == OP_QUIT);
        latch_next = latch_reg;
        if (consume && op.kind == OP_AXIS)
            latch_next[op.slot] = want;

        phase_next = phase_reg;
        if (go && two_step)
            phase_next = 1'b1;
        else if (consume)
            phase_next = 1'b0;

        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        oquit_next     = oquit_reg;
        if (consume)
        begin
            out_valid_next = 1'b1;
            hit_next       = rd_en;
            oquit_next     = quit_next;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            latch_reg[0]  <= LATCH_ZERO;
            latch_reg[1]  <= LATCH_ZERO;
            phase_reg     <= 1'b0;
            quit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            latch_reg     <= latch_next;
            phase_reg     <= phase_next;
            quit_reg      <= quit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        oquit_reg <= oquit_next;
    end

    // read data stays put while the result waits: no new read until it is taken
    gekq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (push_entry),
        .rd_en   (rd_en),
        .rd_addr (rp_reg),
        .rd_data (rd_data)
    );

    assign out_valid   = out_valid_reg;
    assign key_valid   = hit_reg;
    assign key_pressed = hit_reg && rd_data[ENTRY_W-1];
    assign key_action  = hit_reg ? rd_data[ACT_W-1:0] : ACT_NONE;
    assign quit_flag   = oquit_reg;

`ifndef ASSERT_OFF
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wp_inc != rp_reg))
        else $error("action queue written while full");

    a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (wp_reg != rp_reg))
        else $error("action queue read while empty");

    a_phase_on_axis: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (op_valid && op.kind == OP_AXIS))
        else $error("second axis write pending without an axis transaction");

    a_quit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        quit_reg |=> quit_reg)
        else $error("quit flag cleared");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg <= PTR_W'(QUEUE_DEPTH - 1)) && (rp_reg <= PTR_W'(QUEUE_DEPTH - 1)))
        else $error("queue pointer out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(rd_data) && $stable(hit_reg)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import gekq_pkg::*;

    localparam int QDEPTH      = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;

    localparam logic             CMD_EVENT   = ~CMD_POP;
    localparam logic [1:0]       EV_OTHER    = 2'd2;
    localparam logic [1:0]       EV_SPARE    = 2'd3;
    localparam logic [CODE_W-1:0] ABS_OTHER  = 10'd2;
    localparam logic [CODE_W-1:0] KEY_BTN_A  = 10'd304;
    localparam logic [CODE_W-1:0] KEY_UP     = 10'd103;
    localparam logic [CODE_W-1:0] KEY_ESC    = 10'd1;
    localparam logic [CODE_W-1:0] KEY_UNBOUND = 10'd1023;

    typedef struct packed {
        logic             valid;
        logic             pressed;
        logic [ACT_W-1:0] action;
        logic             quit;
    } key_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic cmd;
    logic [1:0] event_type;
    logic [CODE_W-1:0] event_code;
    logic signed [VAL_W-1:0] event_value;
    logic out_valid;
    logic out_ready;
    logic key_valid;
    logic key_pressed;
    logic [ACT_W-1:0] key_action;
    logic quit_flag;

    // evdev codes that are bound to an action, and the action of each
    logic [CODE_W-1:0] bound_codes [24] = '{
        10'd103, 10'd108, 10'd105, 10'd106, 10'd304, 10'd305, 10'd307, 10'd308,
        10'd310, 10'd311, 10'd312, 10'd313, 10'd317, 10'd318, 10'd315, 10'd314,
        10'd115, 10'd114, 10'd1,   10'd28,  10'd57,  10'd29,  10'd42,  10'd15
    };
    logic [ACT_W-1:0] bound_actions [24] = '{
        ACT_UP, ACT_DOWN, ACT_LEFT, ACT_RIGHT, ACT_FIRE, ACT_USE, ACT_RUN, ACT_AUTOMAP,
        ACT_STRAFE_L, ACT_STRAFE_R, ACT_WEAPON3, ACT_WEAPON4, ACT_WEAPON1, ACT_WEAPON2,
        ACT_ENTER, ACT_ESCAPE, ACT_EQUALS, ACT_MINUS,
        ACT_ESCAPE, ACT_ENTER, ACT_USE, ACT_FIRE, ACT_RUN, ACT_AUTOMAP
    };

    // predicted state of the block
    latch_t             latch_state [2];
    logic [ENTRY_W-1:0] action_fifo [QDEPTH];
    int                 fifo_wr;
    int                 fifo_rd;
    logic               quit_seen;
    logic [THR_W-1:0]   press_thr;
    logic [THR_W-1:0]   release_thr;

    key_result_t expected_keys [$];
    int error_count = 0;
    int cycle_count;
    bit gaps_on;
    bit stalls_on;

    gamepad_event_key_queue #(
        .QUEUE_DEPTH(QDEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .event_type (event_type),
        .event_code (event_code),
        .event_value(event_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_valid  (key_valid),
        .key_pressed(key_pressed),
        .key_action (key_action),
        .quit_flag  (quit_flag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ACT_W-1:0] key_to_action(input logic [CODE_W-1:0] code);
        for (int i = 0; i < 24; i++)
        begin
            if (bound_codes[i] == code)
                return bound_actions[i];
        end
        return ACT_NONE;
    endfunction

    function automatic int queue_fill();
        return (fifo_wr - fifo_rd + QDEPTH) % QDEPTH;
    endfunction

    function automatic void enqueue_action(input logic pressed, input logic [ACT_W-1:0] act);
        int nxt;
        if (act == ACT_NONE)
            return;
        nxt = (fifo_wr + 1) % QDEPTH;
        if (nxt == fifo_rd)
            return;
        action_fifo[fifo_wr] = {pressed, act};
        fifo_wr = nxt;
    endfunction

    function automatic void apply_axis(input logic [CODE_W-1:0] code, input int sample);
        int slot;
        int pt;
        int rt;
        int pos;
        latch_t old_l;
        latch_t new_l;
        logic [ACT_W-1:0] neg_act;
        logic [ACT_W-1:0] pos_act;
        if (code == ABS_X)
        begin
            slot = 0; neg_act = ACT_LEFT; pos_act = ACT_RIGHT;
        end
        else if (code == ABS_Y)
        begin
            slot = 1; neg_act = ACT_UP; pos_act = ACT_DOWN;
        end
        else
            return;
        pos = sample;
        if (pos > int'(AXIS_FULL))
            pos = int'(AXIS_FULL);
        if (pos < -int'(AXIS_FULL))
            pos = -int'(AXIS_FULL);
        pt = int'(press_thr);
        rt = int'(release_thr);
        old_l = latch_state[slot];
        new_l = old_l;
        // press compare wins over release when the thresholds overlap
        if (pos >= pt)
            new_l = LATCH_POS;
        else if (pos <= -pt)
            new_l = LATCH_NEG;
        else if (pos > -rt && pos < rt)
            new_l = LATCH_ZERO;
        if (new_l == old_l)
            return;
        if (old_l != LATCH_ZERO)
            enqueue_action(1'b0, (old_l == LATCH_NEG) ? neg_act : pos_act);
        if (new_l != LATCH_ZERO)
            enqueue_action(1'b1, (new_l == LATCH_NEG) ? neg_act : pos_act);
        latch_state[slot] = new_l;
    endfunction

    function automatic void predict_item(input logic c, input logic [1:0] t,
                                         input logic [CODE_W-1:0] code,
                                         input logic signed [VAL_W-1:0] v);
        key_result_t r;
        int sv;
        r = '0;
        sv = int'(v);
        if (c == CMD_POP)
        begin
            if (fifo_rd != fifo_wr)
            begin
                r.valid   = 1'b1;
                r.pressed = action_fifo[fifo_rd][ACT_W];
                r.action  = action_fifo[fifo_rd][ACT_W-1:0];
                fifo_rd   = (fifo_rd + 1) % QDEPTH;
            end
        end
        else if (t == EV_KEY)
        begin
            if (code == MODE_BUTTON)
            begin
                if (sv == 1)
                    quit_seen = 1'b1;
            end
            else if (sv <= 1)
                enqueue_action(sv != 0, key_to_action(code));
        end
        else if (t == EV_ABS)
            apply_axis(code, sv);
        r.quit = quit_seen;
        expected_keys.push_back(r);
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        key_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_keys.size() == 0)
            begin
                $error("result transaction with nothing outstanding");
                error_count++;
            end
            else
            begin
                want = expected_keys.pop_front();
                compare_field("key_valid", 8'(want.valid), 8'(key_valid));
                compare_field("key_pressed", 8'(want.pressed), 8'(key_pressed));
                compare_field("key_action", 8'(want.action), 8'(key_action));
                compare_field("quit_flag", 8'(want.quit), 8'(quit_flag));
            end
        end
    end

    initial
    begin : result_sink
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("gamepad_event_key_queue regression: fail");
        $finish;
    end

    // valid is left high after acceptance; the next call either
    // replaces the payload or drops valid for a gap
    task automatic drive_item(input logic c, input logic [1:0] t,
                              input logic [CODE_W-1:0] code, input int value);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        cmd         <= c;
        event_type  <= t;
        event_code  <= code;
        event_value <= VAL_W'(value);
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        predict_item(c, t, code, VAL_W'(value));
    endtask

    task automatic send_key(input logic [CODE_W-1:0] code, input int value);
        drive_item(CMD_EVENT, EV_KEY, code, value);
    endtask

    task automatic send_axis(input logic [CODE_W-1:0] code, input int value);
        drive_item(CMD_EVENT, EV_ABS, code, value);
    endtask

    // event fields of a pop carry junk
    task automatic send_pop();
        drive_item(CMD_POP, 2'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 1023)),
                   int'($urandom_range(0, 16383)));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_keys.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == REG_PRESS_THR)
            press_thr = data;
        else
            release_thr = data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int axis_sample();
        int pt;
        int rt;
        pt = int'(press_thr);
        rt = int'(release_thr);
        case ($urandom_range(0, 11))
            0:       return pt;
            1:       return pt - 1;
            2:       return -pt;
            3:       return -pt + 1;
            4:       return rt;
            5:       return rt - 1;
            6:       return -rt;
            7:       return -rt + 1;
            8:       return int'($urandom_range(0, 16383)) - 8192;
            default: return int'($urandom_range(0, 8192)) - 4096;
        endcase
    endfunction

    task automatic send_random_item();
        int pick;
        int value;
        logic [CODE_W-1:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            send_pop();
        else if (pick < 68)
        begin
            if ($urandom_range(0, 15) == 0)
                code = MODE_BUTTON;
            else
                code = bound_codes[$urandom_range(0, 23)];
            case ($urandom_range(0, 9))
                0:       value = 2;
                1:       value = -int'($urandom_range(1, 8192));
                2:       value = $urandom_range(2, 8191);
                default: value = $urandom_range(0, 1);
            endcase
            send_key(code, value);
        end
        else if (pick < 90)
        begin
            if ($urandom_range(0, 9) == 0)
                code = CODE_W'($urandom_range(2, 1023));
            else
                code = $urandom_range(0, 1) ? ABS_Y : ABS_X;
            send_axis(code, axis_sample());
        end
        else
            drive_item(CMD_EVENT, 2'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 1023)),
                       int'($urandom_range(0, 16383)));
    endtask

    task automatic test_empty_pop();
        send_pop();
    endtask

    task automatic test_key_events();
        // mode button: only a value of one latches quit, nothing is queued
        send_key(MODE_BUTTON, 2);
        send_key(MODE_BUTTON, 0);
        send_key(MODE_BUTTON, -1);
        send_key(KEY_BTN_A, 1);
        send_key(KEY_BTN_A, 2);
        send_key(KEY_BTN_A, 0);
        send_key(KEY_UP, -8192);
        send_key(KEY_ESC, 1);
        send_key(KEY_UNBOUND, 1);
        drive_item(CMD_EVENT, EV_OTHER, KEY_BTN_A, 1);
        drive_item(CMD_EVENT, EV_SPARE, KEY_BTN_A, 1);
        send_key(MODE_BUTTON, 1);
        repeat (5) send_pop();
    endtask

    task automatic test_axis_latch();
        send_axis(ABS_X, 8191);
        send_axis(ABS_X, 800);
        send_axis(ABS_X, -8192);
        send_axis(ABS_Y, 1800);
        send_axis(ABS_Y, -799);
        send_axis(ABS_OTHER, 4096);
        repeat (6) send_pop();
    endtask

    task automatic test_queue_full();
        wait_idle();
        write_reg(REG_PRESS_THR, PRESS_THR_RESET);
        write_reg(REG_RELEASE_THR, RELEASE_THR_RESET);
        send_axis(ABS_X, 4096);
        while (queue_fill() != 0)
            send_pop();
        while (queue_fill() < QDEPTH - 2)
            send_key(bound_codes[$urandom_range(0, 23)], $urandom_range(0, 1));
        // one slot left: the release of right fits, the press of left is lost
        send_axis(ABS_X, -4096);
        repeat (4) send_key(bound_codes[$urandom_range(0, 23)], 1);
        while (queue_fill() != 0)
            send_pop();
        send_pop();
    endtask

    task automatic test_random_traffic(input logic [THR_W-1:0] pt, input logic [THR_W-1:0] rt,
                                       input int count, input bit quiet);
        wait_idle();
        write_reg(REG_PRESS_THR, pt);
        write_reg(REG_RELEASE_THR, rt);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                gaps_on   = !quiet && $urandom_range(0, 3) != 0;
                stalls_on = !quiet && $urandom_range(0, 3) != 0;
            end
            send_random_item();
        end
    endtask

    initial
    begin : run_tests
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_PRESS_THR;
        cfg_data    = '0;
        in_valid    = 1'b0;
        cmd         = CMD_EVENT;
        event_type  = EV_KEY;
        event_code  = '0;
        event_value = '0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        latch_state[0] = LATCH_ZERO;
        latch_state[1] = LATCH_ZERO;
        fifo_wr     = 0;
        fifo_rd     = 0;
        quit_seen   = 1'b0;
        press_thr   = PRESS_THR_RESET;
        release_thr = RELEASE_THR_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_pop();
        test_key_events();
        test_axis_latch();
        test_random_traffic(PRESS_THR_RESET, RELEASE_THR_RESET, 250, 1'b0);
        test_random_traffic(13'd0, 13'd0, 150, 1'b0);
        test_queue_full();
        test_random_traffic(13'd4096, 13'd4096, 150, 1'b0);
        test_random_traffic(13'd8191, 13'd8191, 150, 1'b0);
        test_random_traffic(13'd4096, 13'd0, 150, 1'b0);
        test_random_traffic(13'd0, 13'd4096, 150, 1'b0);
        test_random_traffic(THR_W'($urandom_range(0, 8191)), THR_W'($urandom_range(0, 8191)),
                            200, 1'b0);
        test_random_traffic(THR_W'($urandom_range(0, 4096)), THR_W'($urandom_range(0, 4096)),
                            250, 1'b1);
        wait_idle();

        if (error_count == 0)
            $display("gamepad_event_key_queue regression: pass");
        else
            $display("gamepad_event_key_queue regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gekq_pkg.sv
src/gekq_ram.sv
src/gekq_front.sv
src/gekq_fifo.sv
src/gekq_back.sv
src/gamepad_event_key_queue.sv
bench/testbench.sv
